// ----- rtl/ttf_pkg.sv -----
package ttf_pkg;

   localparam int OUT_FRAC_BITS = 14;
   localparam int CoordBits = 32;
   localparam int WideBits = 67;
   localparam int ScaleBits = 30;

   typedef logic signed [WideBits-1:0] wide_type;

   typedef struct packed {
      logic        start;
      logic [5:0]  frac;
   } norm_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } norm_status_type;

   function automatic logic [6:0] bit_length(input logic [WideBits-1:0] m);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < WideBits; i++) begin
         if (m[i]) begin
            n = 7'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// ----- rtl/ttf_normalize.sv -----
module ttf_normalize (
   input  logic                        clock,
   input  logic                        reset,
   input  ttf_pkg::norm_req_type       req,
   input  ttf_pkg::wide_type           vec_x,
   input  ttf_pkg::wide_type           vec_y,
   input  ttf_pkg::wide_type           vec_z,
   output ttf_pkg::norm_status_type    status,
   output logic signed [31:0]          out_x,
   output logic signed [31:0]          out_y,
   output logic signed [31:0]          out_z
);
   import ttf_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCALE = 6'b000010,
      S_SQ    = 6'b000100,
      S_SQRT  = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [WideBits-1:0] mag_ff [3];
   logic [WideBits-1:0] mag_in [3];
   logic [2:0] neg_ff, neg_in;
   logic [1:0] idx_ff, idx_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [5:0] frac_ff, frac_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [61:0] num_ff, num_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] res_ff [3];
   logic [31:0] res_in [3];
   logic zero_ff, zero_in;

   logic [WideBits-1:0] all_or;
   logic [6:0] len;
   logic [63:0] sq;
   logic [65:0] trial_rem;
   logic [65:0] trial_sub;
   logic [32:0] dtrial;

   assign all_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign len = bit_length(all_or);
   assign sq = mag_ff[idx_ff][31:0] * mag_ff[idx_ff][31:0];
   assign trial_rem = {rem_ff, acc_ff[63:62]};
   assign trial_sub = {root_ff, 2'b01};
   assign dtrial = {quo_ff, num_ff[61]};

   always_comb begin
      state_in = state_ff;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = mag_ff[i];
         res_in[i] = res_ff[i];
      end
      neg_in = neg_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      frac_in = frac_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      zero_in = zero_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               neg_in = {vec_z[WideBits-1], vec_y[WideBits-1], vec_x[WideBits-1]};
               mag_in[0] = vec_x[WideBits-1] ? WideBits'(-vec_x) : vec_x;
               mag_in[1] = vec_y[WideBits-1] ? WideBits'(-vec_y) : vec_y;
               mag_in[2] = vec_z[WideBits-1] ? WideBits'(-vec_z) : vec_z;
               frac_in = req.frac;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (len == '0) begin
               zero_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  res_in[i] = '0;
               end
               state_in = S_DONE;
            end else begin
               zero_in = 1'b0;
               for (int i = 0; i < 3; i++) begin
                  if (len > 7'(ScaleBits)) begin
                     mag_in[i] = mag_ff[i] >> (len - 7'(ScaleBits));
                  end else begin
                     mag_in[i] = mag_ff[i] << (7'(ScaleBits) - len);
                  end
               end
               idx_in = '0;
               acc_in = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            acc_in = acc_ff + sq;
            if (idx_ff == 2'd2) begin
               rem_in = '0;
               root_in = '0;
               cnt_in = '0;
               state_in = S_SQRT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_SQRT: begin
            acc_in = {acc_ff[61:0], 2'b00};
            if (trial_rem >= trial_sub) begin
               rem_in = 64'(trial_rem - trial_sub);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = trial_rem[63:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd31) begin
               idx_in = '0;
               cnt_in = '0;
               quo_in = '0;
               num_in = 62'(mag_ff[0][29:0]) << frac_ff;
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_DIV: begin
            num_in = {num_ff[60:0], 1'b0};
            if (dtrial >= {1'b0, root_ff}) begin
               quo_in = 32'(dtrial - {1'b0, root_ff});
               rem_in = {rem_ff[62:0], 1'b1};
            end else begin
               quo_in = dtrial[31:0];
               rem_in = {rem_ff[62:0], 1'b0};
            end
            if (cnt_ff == 6'd61) begin
               res_in[idx_ff] = neg_ff[idx_ff] ? -rem_in[31:0] : rem_in[31:0];
               cnt_in = '0;
               quo_in = '0;
               if (idx_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + 2'd1;
                  num_in = 62'(mag_ff[idx_ff + 2'd1][29:0]) << frac_ff;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      for (int i = 0; i < 3; i++) begin
         mag_ff[i] <= mag_in[i];
         res_ff[i] <= res_in[i];
      end
      neg_ff <= neg_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      frac_ff <= frac_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      zero_ff <= zero_in;
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = (state_ff == S_DONE);
   assign status.zero = zero_ff;
   assign out_x = res_ff[0];
   assign out_y = res_ff[1];
   assign out_z = res_ff[2];

   a_done_from_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("done not followed by idle");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQ || state_ff == S_DIV) |-> (idx_ff != 2'd3))
      else $error("component index out of range");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (req.start && state_ff == S_IDLE) |=> (state_ff == S_SCALE))
      else $error("start not taken");

endmodule

// ----- rtl/triangle_tangent_frame.sv -----
// Tangent unit: vertices arrive one per transaction; the first two of each
// triangle are stored and the third starts the computation, after which three
// tangent transactions leave in vertex order, the third with tlast. The next
// vertex is taken only once the third tangent has been accepted, and holding
// rsp_tready low holds it back. The shared normalizer does a 32-step square
// root per use and a 62-step restoring divide per component. It is used once
// for the bitangent and once per vertex. Each vertex also needs its cross
// product and the output handshake, after the determinant and the bitangent
// have been computed. Degenerate results carry a zero tangent.
module triangle_tangent_frame (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tan_x, tan_y, tan_z, degenerate, then zero fill
   output logic [55:0]  rsp_tdata,
   output logic         rsp_tlast
);
   import ttf_pkg::*;

   typedef enum logic [7:0] {
      T_IN    = 8'b00000001,
      T_DET   = 8'b00000010,
      T_BVEC  = 8'b00000100,
      T_BNORM = 8'b00001000,
      T_CROSS = 8'b00010000,
      T_TNORM = 8'b00100000,
      T_OUT   = 8'b01000000,
      T_WAIT  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [31:0] store_ff [16];
   logic [31:0] cur_ff [8];
   logic [1:0] vtx_ff, vtx_in;
   logic [2:0] step_ff, step_in;
   logic signed [65:0] pa_ff, pa_in;
   wide_type acc_ff [3];
   wide_type acc_in [3];
   logic dneg_ff, dneg_in;
   logic bad_ff, bad_in;
   logic signed [31:0] b_ff [3];
   logic signed [31:0] b_in [3];
   logic [55:0] out_ff, out_in;
   logic last_ff, last_in;
   logic valid_ff, valid_in;
   logic start;
   logic [5:0] frac;
   norm_req_type nreq;
   norm_status_type nst;
   logic signed [31:0] nx, ny, nz;
   logic signed [32:0] su, sv, ru, rv, q0, q1;
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic [31:0] vin [8];
   logic signed [31:0] nrm [3];
   logic [1:0] ci, cj;

   for (genvar g = 0; g < 8; g++) begin : g_unpack
      assign vin[g] = req_tdata[32*g +: 32];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm[i] = (vtx_ff == 2'd2) ? cur_ff[3+i]
                : (vtx_ff == 2'd1) ? store_ff[11+i] : store_ff[3+i];
      end
   end

   assign su = 33'(signed'(store_ff[14])) - 33'(signed'(store_ff[6]));
   assign sv = 33'(signed'(store_ff[15])) - 33'(signed'(store_ff[7]));
   assign ru = 33'(signed'(cur_ff[6])) - 33'(signed'(store_ff[6]));
   assign rv = 33'(signed'(cur_ff[7])) - 33'(signed'(store_ff[7]));

   always_comb begin
      q0 = '0;
      q1 = '0;
      ci = '0;
      cj = '0;
      ma = '0;
      mb = '0;
      case (step_ff[1:0])
         2'd0: begin
            ci = 2'd0;
         end
         2'd1: begin
            ci = 2'd1;
         end
         default: begin
            ci = 2'd2;
         end
      endcase
      case (ci)
         2'd0: begin
            q0 = 33'(signed'(store_ff[8])) - 33'(signed'(store_ff[0]));
            q1 = 33'(signed'(cur_ff[0])) - 33'(signed'(store_ff[0]));
         end
         2'd1: begin
            q0 = 33'(signed'(store_ff[9])) - 33'(signed'(store_ff[1]));
            q1 = 33'(signed'(cur_ff[1])) - 33'(signed'(store_ff[1]));
         end
         default: begin
            q0 = 33'(signed'(store_ff[10])) - 33'(signed'(store_ff[2]));
            q1 = 33'(signed'(cur_ff[2])) - 33'(signed'(store_ff[2]));
         end
      endcase
      cj = (ci == 2'd0) ? 2'd1 : ((ci == 2'd1) ? 2'd2 : 2'd0);
      case (state_ff)
         T_DET: begin
            ma = step_ff[0] ? ru : su;
            mb = step_ff[0] ? sv : rv;
         end
         T_BVEC: begin
            ma = step_ff[2] ? ru : su;
            mb = step_ff[2] ? q0 : q1;
         end
         default: begin
            ma = step_ff[2] ? 33'(b_ff[cj]) : 33'(b_ff[(cj == 2'd2) ? 2'd0 : cj + 2'd1]);
            mb = step_ff[2] ? 33'(nrm[(cj == 2'd2) ? 2'd0 : cj + 2'd1])
                            : 33'(nrm[cj]);
         end
      endcase
   end

   assign prod = ma * mb;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      vtx_in = vtx_ff;
      step_in = step_ff;
      pa_in = pa_ff;
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = acc_ff[i];
         b_in[i] = b_ff[i];
      end
      dneg_in = dneg_ff;
      bad_in = bad_ff;
      out_in = out_ff;
      last_in = last_ff;
      valid_in = valid_ff;
      start = 1'b0;
      frac = 6'd30;
      case (state_ff)
         T_IN: begin
            if (req_tvalid) begin
               if (phase_ff == 2'd1) begin
                  phase_in = 2'd2;
               end else if (phase_ff == 2'd2) begin
                  phase_in = 2'd0;
                  step_in = '0;
                  state_in = T_DET;
               end else begin
                  phase_in = 2'd1;
               end
            end
         end
         T_DET: begin
            if (step_ff[0]) begin
               acc_in[0] = WideBits'(pa_ff) - WideBits'(prod);
               step_in = '0;
               state_in = T_BVEC;
            end else begin
               pa_in = prod;
               step_in = 3'd1;
            end
         end
         T_BVEC: begin
            if (step_ff == 3'd0) begin
               dneg_in = acc_ff[0][WideBits-1];
               bad_in = (acc_ff[0] == '0);
            end
            if (step_ff[2]) begin
               acc_in[step_ff[1:0]] = dneg_ff
                  ? WideBits'(prod) - WideBits'(pa_ff)
                  : WideBits'(pa_ff) - WideBits'(prod);
               step_in = (step_ff[1:0] == 2'd2) ? 3'd0 : {1'b0, step_ff[1:0] + 2'd1};
               if (step_ff[1:0] == 2'd2) begin
                  state_in = T_BNORM;
               end
            end else begin
               pa_in = prod;
               step_in = {1'b1, step_ff[1:0]};
            end
         end
         T_BNORM: begin
            if (bad_ff) begin
               vtx_in = '0;
               state_in = T_OUT;
               out_in = 56'd1 << 48;
            end else if (!nst.busy && step_ff == 3'd0) begin
               start = 1'b1;
               step_in = 3'd1;
            end else if (nst.done) begin
               bad_in = nst.zero;
               b_in[0] = nx;
               b_in[1] = ny;
               b_in[2] = nz;
               vtx_in = '0;
               step_in = '0;
               state_in = nst.zero ? T_BNORM : T_CROSS;
            end
         end
         T_CROSS: begin
            if (step_ff[2]) begin
               acc_in[step_ff[1:0]] = WideBits'(prod) - WideBits'(pa_ff);
               step_in = (step_ff[1:0] == 2'd2) ? 3'd0 : {1'b0, step_ff[1:0] + 2'd1};
               if (step_ff[1:0] == 2'd2) begin
                  state_in = T_TNORM;
               end
            end else begin
               pa_in = prod;
               step_in = {1'b1, step_ff[1:0]};
            end
         end
         T_TNORM: begin
            frac = 6'(OUT_FRAC_BITS);
            if (!nst.busy && step_ff == 3'd0) begin
               start = 1'b1;
               step_in = 3'd1;
            end else if (nst.done) begin
               step_in = '0;
               out_in = {7'd0, nst.zero,
                         nst.zero ? 48'd0 : {nz[15:0], ny[15:0], nx[15:0]}};
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (bad_ff) begin
               out_in = 56'd1 << 48;
            end
            valid_in = 1'b1;
            last_in = (vtx_ff == 2'd2);
            state_in = T_WAIT;
         end
         T_WAIT: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               step_in = '0;
               if (vtx_ff == 2'd2) begin
                  state_in = T_IN;
               end else begin
                  vtx_in = vtx_ff + 2'd1;
                  state_in = bad_ff ? T_OUT : T_CROSS;
               end
            end
         end
         default: begin
            state_in = T_IN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IN;
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
      if (state_ff == T_IN && req_tvalid) begin
         for (int i = 0; i < 8; i++) begin
            if (phase_ff == 2'd1) begin
               store_ff[8+i] <= vin[i];
            end else if (phase_ff != 2'd2) begin
               store_ff[i] <= vin[i];
            end
            cur_ff[i] <= vin[i];
         end
      end
      vtx_ff <= vtx_in;
      step_ff <= step_in;
      pa_ff <= pa_in;
      for (int i = 0; i < 3; i++) begin
         acc_ff[i] <= acc_in[i];
         b_ff[i] <= b_in[i];
      end
      dneg_ff <= dneg_in;
      bad_ff <= bad_in;
      out_ff <= out_in;
      last_ff <= last_in;
   end

   assign nreq.start = start;
   assign nreq.frac = frac;

   ttf_normalize u_norm (
      .clock  (clock),
      .reset  (reset),
      .req    (nreq),
      .vec_x  (acc_ff[0]),
      .vec_y  (acc_ff[1]),
      .vec_z  (acc_ff[2]),
      .status (nst),
      .out_x  (nx),
      .out_y  (ny),
      .out_z  (nz)
   );

   assign req_tready = (state_ff == T_IN);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tlast = last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("vertex phase out of range");
   a_last_third: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (vtx_ff == 2'd2))
      else $error("tlast off the third vertex");

endmodule
